@@ src/llps_pkg.sv @@
// Shared types and constants of the load-line parser.
`default_nettype none

package llps_pkg;

  // Input operation codes carried in the slave tuser
  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Characters of interest in the feed
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Number limits
  localparam int unsigned NUM_MAX    = 1000;
  localparam int unsigned LOAD_MAX   = 100;
  localparam int unsigned NUM_FIELDS = 5;

  localparam int unsigned WINDOW_W = 31;

  // Line event reported with every result
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_ACCEPTED  = 2'd1,
    EV_MALFORMED = 2'd2,
    EV_EMPTY     = 2'd3
  } llps_event_t;

  typedef logic [6:0] load_t;

  // One input item as held in the input register
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [31:0] now_ms;
  } llps_item_t;

  // One result item
  typedef struct packed {
    logic        fresh;
    load_t [4:0] loads;
    llps_event_t line_event;
  } llps_result_t;

endpackage

`default_nettype wire

@@ src/llps_in_reg.sv @@
// Input register of the load-line parser: holds one accepted transaction.
`default_nettype none

module llps_in_reg
  import llps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire llps_item_t in_item,
  output logic            item_valid,
  output llps_item_t      item,
  input  wire logic       item_take
);

  // Room when empty or when the held item leaves this cycle
  assign in_ready = !item_valid || item_take;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ src/llps_step.sv @@
// Freshness check and result forming of the load-line parser for one item.
`default_nettype none

module llps_step
  import llps_pkg::*;
(
  input  wire logic [WINDOW_W-1:0] window,
  input  wire logic [31:0]         now_ms,
  input  wire logic [31:0]         stamp,
  input  wire logic                have_values,
  input  wire logic                accepted,
  input  wire load_t [4:0]         loads,
  input  wire llps_event_t         line_event,
  output llps_result_t             result
);

  logic [31:0] age;
  logic        fresh;

  // Freshness after this step; a fresh accept has age zero
  always_comb begin
    age   = now_ms - stamp;
    fresh = have_values &&
            (accepted || age[31] || (age[30:0] <= window));
    result.fresh      = fresh;
    result.loads      = fresh ? loads : '0;
    result.line_event = line_event;
  end

endmodule

`default_nettype wire

@@ src/llps_out_reg.sv @@
// Result register of the load-line parser: drives the master stream.
`default_nettype none

module llps_out_reg
  import llps_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire llps_result_t result_in,
  output logic              out_valid,
  input  wire logic         out_ready,
  output llps_result_t      result
);

  // Valid flag: set on load, cleared once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

`default_nettype wire

@@ src/llps_parse.sv @@
// Parser state, stored loads, freshness check and result forming for one item.
`default_nettype none

module llps_parse
  import llps_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [WINDOW_W-1:0] cfg_wr_data,
  input  wire logic                step,
  input  wire llps_item_t          item,
  output llps_result_t             result
);

  localparam int unsigned LEN_W = $clog2(LINE_LIMIT + 1);
  localparam int unsigned FI_W  = $clog2(NUM_FIELDS + 1);

  // Registers
  logic [WINDOW_W-1:0] fresh_window_ms;
  logic                have_values;
  logic [31:0]         update_stamp;
  load_t [4:0]         stored_loads;
  load_t [4:0]         pending_loads;
  logic [LEN_W-1:0]    line_length;
  logic [FI_W-1:0]     field_index;
  logic                in_number;
  logic [9:0]          number_value;
  logic                line_bad;

  // Next values
  logic                have_values_next;
  logic [31:0]         update_stamp_next;
  load_t [4:0]         stored_loads_next;
  load_t [4:0]         pending_loads_next;
  logic [LEN_W-1:0]    line_length_next;
  logic [FI_W-1:0]     field_index_next;
  logic                in_number_next;
  logic [9:0]          number_value_next;
  logic                line_bad_next;

  // Working signals
  logic                is_newline;
  logic                is_digit;
  logic                is_blank;
  logic [3:0]          digit;
  logic [13:0]         product;
  logic                commit_do;
  load_t               clamped;
  load_t [4:0]         pending_commit;
  logic [FI_W-1:0]     field_commit;
  logic                accepted;
  llps_event_t         line_event;

  // Byte classes
  always_comb begin
    is_newline = (item.data_byte == CHAR_NEWLINE);
    is_digit   = item.data_byte inside {[CHAR_ZERO:CHAR_NINE]};
    is_blank   = (item.data_byte == CHAR_SPACE) || (item.data_byte == CHAR_TAB);
    digit      = 4'(item.data_byte - CHAR_ZERO);
    product    = 14'(number_value) * 14'd10 + 14'(digit);
  end

  // Closing the number under way into the pending slot
  always_comb begin
    commit_do      = in_number && (field_index < FI_W'(NUM_FIELDS));
    clamped        = (number_value > 10'(LOAD_MAX)) ? 7'(LOAD_MAX) : number_value[6:0];
    pending_commit = pending_loads;
    if (commit_do) begin
      pending_commit[3'(field_index)] = clamped;
    end
    field_commit = commit_do ? field_index + 1'b1 : field_index;
  end

  // Parser step
  always_comb begin
    have_values_next   = have_values;
    update_stamp_next  = update_stamp;
    stored_loads_next  = stored_loads;
    pending_loads_next = pending_loads;
    line_length_next   = line_length;
    field_index_next   = field_index;
    in_number_next     = in_number;
    number_value_next  = number_value;
    line_bad_next      = line_bad;
    line_event         = EV_NONE;
    accepted           = 1'b0;
    case (item.op)
      OP_FEED: begin
        if (is_newline) begin
          pending_loads_next = pending_commit;
          if (!line_bad && field_commit == FI_W'(NUM_FIELDS) &&
              line_length < LEN_W'(LINE_LIMIT)) begin
            accepted          = 1'b1;
            stored_loads_next = pending_commit;
            update_stamp_next = item.now_ms;
            have_values_next  = 1'b1;
            line_event        = EV_ACCEPTED;
          end else if (line_length != '0) begin
            line_event = EV_MALFORMED;
          end else begin
            line_event = EV_EMPTY;
          end
          line_length_next  = '0;
          field_index_next  = '0;
          in_number_next    = 1'b0;
          number_value_next = '0;
          line_bad_next     = 1'b0;
        end else begin
          if (line_length < LEN_W'(LINE_LIMIT)) begin
            line_length_next = line_length + 1'b1;
          end
          if (!line_bad) begin
            if (is_digit) begin
              if (!in_number) begin
                if (field_index >= FI_W'(NUM_FIELDS)) begin
                  line_bad_next = 1'b1;
                end else begin
                  in_number_next    = 1'b1;
                  number_value_next = 10'(digit);
                end
              end else begin
                number_value_next = product[9:0];
                if (product > 14'(NUM_MAX)) begin
                  line_bad_next = 1'b1;
                end
              end
            end else if (is_blank) begin
              pending_loads_next = pending_commit;
              field_index_next   = field_commit;
              in_number_next     = 1'b0;
              number_value_next  = '0;
            end else begin
              line_bad_next = 1'b1;
            end
          end
        end
      end
      OP_RESTART: begin
        line_length_next  = '0;
        field_index_next  = '0;
        in_number_next    = 1'b0;
        number_value_next = '0;
        line_bad_next     = 1'b0;
      end
      default: ;
    endcase
  end

  // Freshness after this step and result forming
  llps_step u_step (
    .window      (fresh_window_ms),
    .now_ms      (item.now_ms),
    .stamp       (update_stamp),
    .have_values (have_values_next),
    .accepted    (accepted),
    .loads       (stored_loads_next),
    .line_event  (line_event),
    .result      (result)
  );

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_window_ms <= '0;
    end else if (cfg_wr_en) begin
      fresh_window_ms <= cfg_wr_data;
    end
  end

  // Parser control state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_values  <= 1'b0;
      update_stamp <= '0;
      line_length  <= '0;
      field_index  <= '0;
      in_number    <= 1'b0;
      number_value <= '0;
      line_bad     <= 1'b0;
    end else if (step) begin
      have_values  <= have_values_next;
      update_stamp <= update_stamp_next;
      line_length  <= line_length_next;
      field_index  <= field_index_next;
      in_number    <= in_number_next;
      number_value <= number_value_next;
      line_bad     <= line_bad_next;
    end
  end

  // Load values, no reset; stored loads are read only once have_values is set
  always_ff @(posedge clk) begin
    if (step) begin
      stored_loads  <= stored_loads_next;
      pending_loads <= pending_loads_next;
    end
  end

  // Checks
  a_field_bound: assert property (@(posedge clk) disable iff (rst)
    field_index <= FI_W'(NUM_FIELDS))
    else $error("field index beyond five");

  a_number_slot: assert property (@(posedge clk) disable iff (rst)
    in_number |-> (field_index < FI_W'(NUM_FIELDS)))
    else $error("number open with no free slot");

  a_length_sat: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_LIMIT))
    else $error("line length past saturation");

  a_accept_fresh: assert property (@(posedge clk) disable iff (rst)
    (step && line_event == EV_ACCEPTED) |-> result.fresh)
    else $error("accepted line not reported fresh");

  a_accept_stamp: assert property (@(posedge clk) disable iff (rst)
    (step && line_event == EV_ACCEPTED) |=> (have_values && update_stamp == $past(item.now_ms)))
    else $error("accepted line did not stamp the time");

endmodule

`default_nettype wire

@@ src/load_line_parser_with_staleness_core.sv @@
// Top level of the load-line parser with staleness check.
//
// Slave stream: one transaction per item; tuser holds the operation (feed byte,
// time query, restart), tdata the feed byte and the millisecond clock. Master
// stream: one result transaction per item with the five loads and the line
// event. The freshness window is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
//
// An accepted item is held in the input register, and the parser step loads its
// result into the result register that drives the master side. Throughput is one
// item per cycle while the receiver takes results: the parser step is a single
// registered pass between the input register and the result register, with the
// byte-wise multiply-by-ten accumulate as its longest path. When the receiver
// stalls, the held result stays and one further item can be accepted into the
// input register; then tready drops until the result is taken. Reset clears the
// line state, the stored flag and the window; there is no clearing pass and the
// block can accept items as soon as reset is released.
`default_nettype none

module load_line_parser_with_staleness_core
  import llps_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [WINDOW_W-1:0] cfg_wr_data,   // fresh_window_ms
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [39:0]         s_axis_tdata,  // data_byte[7:0], now_ms[39:8]
  input  wire logic [1:0]          s_axis_tuser,  // op[1:0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [39:0]              m_axis_tdata,  // cpu[6:0] net[13:7] xeq[20:14]
                                                  // mem[27:21] pag[34:28] zero[39:35]
  output logic [2:0]               m_axis_tuser   // fresh[0], line_event[2:1]
);

  llps_item_t   in_item;
  llps_item_t   item;
  logic         item_valid;
  logic         step;
  llps_result_t step_result;
  llps_result_t out_result;

  // Unpack the slave transaction
  assign in_item.op        = s_axis_tuser;
  assign in_item.data_byte = s_axis_tdata[7:0];
  assign in_item.now_ms    = s_axis_tdata[39:8];

  // One step whenever an item waits and the result register has room
  assign step = item_valid && (!m_axis_tvalid || m_axis_tready);

  llps_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (step)
  );

  llps_parse #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (item),
    .result      (step_result)
  );

  llps_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .result_in (step_result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (out_result)
  );

  // Pack the master transaction
  assign m_axis_tdata = {5'd0, out_result.loads[4], out_result.loads[3],
                         out_result.loads[2], out_result.loads[1], out_result.loads[0]};
  assign m_axis_tuser = {out_result.line_event, out_result.fresh};

endmodule

`default_nettype wire
